// File: rtl/sparse_table_range_min_max_macros.svh
// Assertion macros shared by the sparse table range query RTL.
`ifndef SPARSE_TABLE_RANGE_MIN_MAX_MACROS_SVH
`define SPARSE_TABLE_RANGE_MIN_MAX_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STRMM_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("strmm: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define STRMM_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("strmm: assertion failed");

`endif

// File: rtl/strmm_pkg.sv
// Shared types and constants of the sparse table range query engine.
package strmm_pkg;

	localparam int POS_W = 10;
	localparam int VAL_W = 32;
	localparam int CNT_W = 11;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_BUILD = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_REVERSED  = 2'd1,
		ST_NOT_BUILT = 2'd2,
		ST_BEYOND    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		RD_BLD_A = 2'd0,
		RD_BLD_B = 2'd1,
		RD_Q_A   = 2'd2,
		RD_Q_B   = 2'd3
	} rd_sel_t;

	typedef struct packed {
		logic    capture;
		logic    load_wr;
		logic    bld_init;
		logic    bld_next_j;
		logic    bld_next_k;
		logic    q_check;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    hold_a;
		logic    tbl_wr;
		logic    set_built;
		logic    finish;
	} dp_cmd_t;

	typedef struct packed {
		logic q_err;
		logic bld_empty;
		logic last_j;
		logic last_k;
	} dp_sts_t;

endpackage

// File: rtl/strmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module strmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/strmm_ctrl.sv
// Controller state machine sequencing load, build and query words.
`include "sparse_table_range_min_max_macros.svh"

module strmm_ctrl import strmm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] item_cmd,
	input  dp_sts_t    sts,
	output logic       busy,
	output dp_cmd_t    dp_cmd
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_SIMPLE = 10'b00_0000_0010,
		S_BINIT  = 10'b00_0000_0100,
		S_BRDA   = 10'b00_0000_1000,
		S_BRDB   = 10'b00_0001_0000,
		S_BWR    = 10'b00_0010_0000,
		S_QCHK   = 10'b00_0100_0000,
		S_QRDA   = 10'b00_1000_0000,
		S_QRDB   = 10'b01_0000_0000,
		S_QCMP   = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		dp_cmd  = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					dp_cmd.capture = 1'b1;
					case (item_cmd)
						CMD_BUILD: state_d = S_BINIT;
						CMD_QUERY: state_d = S_QCHK;
						default:   state_d = S_SIMPLE;
					endcase
				end
			end
			S_SIMPLE: begin
				dp_cmd.load_wr = 1'b1;
				dp_cmd.finish  = 1'b1;
				state_d        = S_IDLE;
			end
			S_BINIT: begin
				dp_cmd.bld_init = 1'b1;
				if (sts.bld_empty) begin
					dp_cmd.set_built = 1'b1;
					dp_cmd.finish    = 1'b1;
					state_d          = S_IDLE;
				end else begin
					state_d = S_BRDA;
				end
			end
			S_BRDA: begin
				dp_cmd.rd_en  = 1'b1;
				dp_cmd.rd_sel = RD_BLD_A;
				state_d       = S_BRDB;
			end
			S_BRDB: begin
				dp_cmd.rd_en  = 1'b1;
				dp_cmd.rd_sel = RD_BLD_B;
				dp_cmd.hold_a = 1'b1;
				state_d       = S_BWR;
			end
			S_BWR: begin
				dp_cmd.tbl_wr = 1'b1;
				if (!sts.last_j) begin
					dp_cmd.bld_next_j = 1'b1;
					state_d           = S_BRDA;
				end else if (!sts.last_k) begin
					dp_cmd.bld_next_k = 1'b1;
					state_d           = S_BRDA;
				end else begin
					dp_cmd.set_built = 1'b1;
					dp_cmd.finish    = 1'b1;
					state_d          = S_IDLE;
				end
			end
			S_QCHK: begin
				dp_cmd.q_check = 1'b1;
				if (sts.q_err) begin
					dp_cmd.finish = 1'b1;
					state_d       = S_IDLE;
				end else begin
					state_d = S_QRDA;
				end
			end
			S_QRDA: begin
				dp_cmd.rd_en  = 1'b1;
				dp_cmd.rd_sel = RD_Q_A;
				state_d       = S_QRDB;
			end
			S_QRDB: begin
				dp_cmd.rd_en  = 1'b1;
				dp_cmd.rd_sel = RD_Q_B;
				dp_cmd.hold_a = 1'b1;
				state_d       = S_QCMP;
			end
			S_QCMP: begin
				dp_cmd.finish = 1'b1;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	`STRMM_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, start && state_q == S_IDLE, state_q != S_IDLE)
	`STRMM_ASSERT_IMPL(a_write_after_read, clk, arst_n, dp_cmd.tbl_wr, $past(dp_cmd.rd_en))
	`STRMM_ASSERT_NEXT(a_finish_to_idle, clk, arst_n, dp_cmd.finish, state_q == S_IDLE)

endmodule

// File: rtl/strmm_dpath.sv
// Datapath: level table memories, build counters, query windows and result registers.
module strmm_dpath import strmm_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int LEVEL_COUNT  = 11,
	parameter int VALUE_BITS   = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       cmd_in,
	input  logic [POS_W-1:0] position,
	input  logic [VAL_W-1:0] value,
	input  logic [POS_W-1:0] range_low,
	input  logic [POS_W-1:0] range_high,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  dp_cmd_t          dp_cmd,
	output dp_sts_t          sts,
	output logic             done,
	output logic [1:0]       status,
	output logic [POS_W-1:0] max_position,
	output logic [VAL_W-1:0] max_value,
	output logic [POS_W-1:0] min_first_position,
	output logic [POS_W-1:0] min_last_position,
	output logic [VAL_W-1:0] min_value
);

	localparam int PW    = $clog2(MAX_ELEMENTS);
	localparam int CW    = $clog2(MAX_ELEMENTS + 1);
	localparam int KW    = $clog2(LEVEL_COUNT);
	localparam int DEPTH = LEVEL_COUNT * MAX_ELEMENTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int EDW   = PW + VALUE_BITS;
	localparam int NW    = (CNT_W > CW) ? CNT_W : CW;
	localparam int QW    = ((POS_W > CW) ? POS_W : CW) + 1;
	localparam int EW    = ((CW > LEVEL_COUNT) ? CW : LEVEL_COUNT) + 1;
	localparam int LW    = POS_W + 1;

	cmd_t             cmd_q;
	logic [POS_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;
	logic [POS_W-1:0] lo_q;
	logic [POS_W-1:0] hi_q;

	logic [CW-1:0] eff_q;
	logic [CW-1:0] eff_d;
	logic          built_q;
	logic [NW-1:0] wr_cnt;

	logic [KW-1:0] lvl_q;
	logic [PW-1:0] j_q;
	logic [EW-1:0] span_q;
	logic [AW-1:0] cur_base_q;
	logic [AW-1:0] prev_base;
	logic [EW-1:0] half;

	logic [AW-1:0] qbase_q;
	logic [PW-1:0] right_q;
	logic [LW-1:0] q_len;
	logic [3:0]    q_lg;
	logic [KW-1:0] q_lg_cap;
	logic [LW-1:0] q_span;

	status_t q_status;
	logic    pos_ok;
	logic    load_we;

	logic [AW-1:0]  raddr;
	logic [AW-1:0]  waddr;
	logic           we;
	logic [EDW-1:0] load_entry;
	logic [VALUE_BITS+VAL_W-1:0] v_ext;

	logic [EDW-1:0] rd_max;
	logic [EDW-1:0] rd_mnf;
	logic [EDW-1:0] rd_mnl;
	logic [EDW-1:0] a_max_q;
	logic [EDW-1:0] a_mnf_q;
	logic [EDW-1:0] a_mnl_q;
	logic [EDW-1:0] pk_max;
	logic [EDW-1:0] pk_mnf;
	logic [EDW-1:0] pk_mnl;

	logic                        done_q;
	status_t                     status_q;
	logic [POS_W-1:0]            max_pos_q;
	logic [VAL_W-1:0]            max_val_q;
	logic [POS_W-1:0]            mnf_pos_q;
	logic [POS_W-1:0]            mnl_pos_q;
	logic [VAL_W-1:0]            min_val_q;
	logic                        res_ok;
	logic [VALUE_BITS+VAL_W-1:0] max_zext;
	logic [VALUE_BITS+VAL_W-1:0] min_zext;

	// Effective element count, clamped into one to the table size.
	assign wr_cnt = NW'(cfg_wdata);

	always_comb begin
		if (wr_cnt == '0) begin
			eff_d = CW'(1);
		end else if (wr_cnt > NW'(MAX_ELEMENTS)) begin
			eff_d = CW'(MAX_ELEMENTS);
		end else begin
			eff_d = CW'(wr_cnt);
		end
	end

	assign pos_ok  = (QW'(pos_q) < QW'(MAX_ELEMENTS));
	assign load_we = dp_cmd.load_wr && (cmd_q == CMD_LOAD) && pos_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_q   <= CW'(1);
			built_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				eff_q   <= eff_d;
				built_q <= 1'b0;
			end else if (load_we) begin
				built_q <= 1'b0;
			end else if (dp_cmd.set_built) begin
				built_q <= 1'b1;
			end
		end
	end

	// Build sweep counters: level, entry within level, window span and level base.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q      <= '0;
			j_q        <= '0;
			span_q     <= '0;
			cur_base_q <= '0;
		end else begin
			if (dp_cmd.bld_init) begin
				lvl_q      <= KW'(1);
				j_q        <= '0;
				span_q     <= EW'(2);
				cur_base_q <= AW'(MAX_ELEMENTS);
			end else if (dp_cmd.bld_next_j) begin
				j_q <= j_q + PW'(1);
			end else if (dp_cmd.bld_next_k) begin
				lvl_q      <= lvl_q + KW'(1);
				j_q        <= '0;
				span_q     <= span_q << 1;
				cur_base_q <= cur_base_q + AW'(MAX_ELEMENTS);
			end
		end
	end

	assign prev_base = cur_base_q - AW'(MAX_ELEMENTS);
	assign half      = span_q >> 1;

	assign sts.bld_empty = (eff_q < CW'(2));
	assign sts.last_j    = ((EW'(j_q) + span_q) == EW'(eff_q));
	assign sts.last_k    = (lvl_q == KW'(LEVEL_COUNT - 1)) || ((span_q << 1) > EW'(eff_q));

	// Query checks in priority order.
	always_comb begin
		if (!built_q) begin
			q_status = ST_NOT_BUILT;
		end else if ((QW'(lo_q) >= QW'(eff_q)) || (QW'(hi_q) >= QW'(eff_q))) begin
			q_status = ST_BEYOND;
		end else if (lo_q > hi_q) begin
			q_status = ST_REVERSED;
		end else begin
			q_status = ST_OK;
		end
	end

	assign sts.q_err = (q_status != ST_OK);

	// Window level is the floor log2 of the range length, capped at the top level.
	always_comb begin
		q_len = LW'(hi_q) - LW'(lo_q) + LW'(1);
		q_lg  = '0;
		for (int i = 0; i < LW; i++) begin
			if (q_len[i]) begin
				q_lg = 4'(i);
			end
		end
		if (5'(q_lg) > 5'(LEVEL_COUNT - 1)) begin
			q_lg_cap = KW'(LEVEL_COUNT - 1);
		end else begin
			q_lg_cap = KW'(q_lg);
		end
		q_span = LW'(1) << q_lg_cap;
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			cmd_q <= cmd_t'(cmd_in);
			pos_q <= position;
			val_q <= value;
			lo_q  <= range_low;
			hi_q  <= range_high;
		end
		if (dp_cmd.q_check) begin
			qbase_q <= AW'(q_lg_cap) * AW'(MAX_ELEMENTS);
			right_q <= PW'(LW'(hi_q) + LW'(1) - q_span);
		end
		if (dp_cmd.hold_a) begin
			a_max_q <= rd_max;
			a_mnf_q <= rd_mnf;
			a_mnl_q <= rd_mnl;
		end
	end

	always_comb begin
		case (dp_cmd.rd_sel)
			RD_BLD_A: raddr = prev_base + AW'(j_q);
			RD_BLD_B: raddr = prev_base + AW'(j_q) + AW'(half);
			RD_Q_A:   raddr = qbase_q + AW'(lo_q);
			RD_Q_B:   raddr = qbase_q + AW'(right_q);
			default:  raddr = '0;
		endcase
	end

	// A load writes level zero of every table with the position and its value.
	assign v_ext      = {{VALUE_BITS{val_q[VAL_W-1]}}, val_q};
	assign load_entry = {PW'(pos_q), v_ext[VALUE_BITS-1:0]};
	assign we         = load_we || dp_cmd.tbl_wr;
	assign waddr      = dp_cmd.tbl_wr ? (cur_base_q + AW'(j_q)) : AW'(pos_q);

	// Held word is the left window, the live read data the right window.
	assign pk_max = ($signed(a_max_q[VALUE_BITS-1:0]) >= $signed(rd_max[VALUE_BITS-1:0]))
		? a_max_q : rd_max;
	assign pk_mnf = ($signed(a_mnf_q[VALUE_BITS-1:0]) <= $signed(rd_mnf[VALUE_BITS-1:0]))
		? a_mnf_q : rd_mnf;
	assign pk_mnl = ($signed(a_mnl_q[VALUE_BITS-1:0]) < $signed(rd_mnl[VALUE_BITS-1:0]))
		? a_mnl_q : rd_mnl;

	strmm_ram #(
		.WIDTH (EDW),
		.DEPTH (DEPTH)
	) u_max_tbl (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (dp_cmd.tbl_wr ? pk_max : load_entry),
		.re    (dp_cmd.rd_en),
		.raddr (raddr),
		.rdata (rd_max)
	);

	strmm_ram #(
		.WIDTH (EDW),
		.DEPTH (DEPTH)
	) u_mnf_tbl (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (dp_cmd.tbl_wr ? pk_mnf : load_entry),
		.re    (dp_cmd.rd_en),
		.raddr (raddr),
		.rdata (rd_mnf)
	);

	strmm_ram #(
		.WIDTH (EDW),
		.DEPTH (DEPTH)
	) u_mnl_tbl (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (dp_cmd.tbl_wr ? pk_mnl : load_entry),
		.re    (dp_cmd.rd_en),
		.raddr (raddr),
		.rdata (rd_mnl)
	);

	// Result word.
	assign res_ok   = (cmd_q == CMD_QUERY) && (q_status == ST_OK);
	assign max_zext = {{VAL_W{1'b0}}, pk_max[VALUE_BITS-1:0]};
	assign min_zext = {{VAL_W{1'b0}}, pk_mnf[VALUE_BITS-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dp_cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.finish) begin
			status_q <= (cmd_q == CMD_QUERY) ? q_status : ST_OK;
			if (res_ok) begin
				max_pos_q <= POS_W'(pk_max[EDW-1:VALUE_BITS]);
				max_val_q <= max_zext[VAL_W-1:0];
				mnf_pos_q <= POS_W'(pk_mnf[EDW-1:VALUE_BITS]);
				mnl_pos_q <= POS_W'(pk_mnl[EDW-1:VALUE_BITS]);
				min_val_q <= min_zext[VAL_W-1:0];
			end else begin
				max_pos_q <= '0;
				max_val_q <= '0;
				mnf_pos_q <= '0;
				mnl_pos_q <= '0;
				min_val_q <= '0;
			end
		end
	end

	assign done               = done_q;
	assign status             = status_q;
	assign max_position       = max_pos_q;
	assign max_value          = max_val_q;
	assign min_first_position = mnf_pos_q;
	assign min_last_position  = mnl_pos_q;
	assign min_value          = min_val_q;

endmodule

// File: rtl/sparse_table_range_min_max.sv
// Top level of the sparse table range minimum and maximum query engine.
//
//   Channel   Handshake               Ports
//   item      start high, busy low    cmd, position, value, range_low, range_high
//   result    done for one cycle      status, max_position, max_value,
//                                     min_first_position, min_last_position, min_value
//   config    cfg_we                  cfg_wdata (element_count)
//
// Every word gives one result word. Load and no-op words run the simple state; a query
// runs check, left read, right read and compare, or only check when its checks fail.
// Done comes in the first idle cycle, so the next word can be accepted while the result
// is shown. A build runs init, then a left read, right read and write per entry, over
// levels k of (n - 2^k + 1) entries, as each table has one read port. Reset clears
// the built flag, sets the count to one and keeps the tables. The receiver cannot stall.
module sparse_table_range_min_max import strmm_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int LEVEL_COUNT  = 11,
	parameter int VALUE_BITS   = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              cmd,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	input  logic [POS_W-1:0]        range_low,
	input  logic [POS_W-1:0]        range_high,
	input  logic                    cfg_we,
	input  logic [CNT_W-1:0]        cfg_wdata,
	output logic                    done,
	output logic [1:0]              status,
	output logic [POS_W-1:0]        max_position,
	output logic signed [VAL_W-1:0] max_value,
	output logic [POS_W-1:0]        min_first_position,
	output logic [POS_W-1:0]        min_last_position,
	output logic signed [VAL_W-1:0] min_value
);

	dp_cmd_t dp_cmd;
	dp_sts_t sts;

	strmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item_cmd (cmd),
		.sts      (sts),
		.busy     (busy),
		.dp_cmd   (dp_cmd)
	);

	strmm_dpath #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.LEVEL_COUNT  (LEVEL_COUNT),
		.VALUE_BITS   (VALUE_BITS)
	) u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd_in             (cmd),
		.position           (position),
		.value              (value),
		.range_low          (range_low),
		.range_high         (range_high),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.dp_cmd             (dp_cmd),
		.sts                (sts),
		.done               (done),
		.status             (status),
		.max_position       (max_position),
		.max_value          (max_value),
		.min_first_position (min_first_position),
		.min_last_position  (min_last_position),
		.min_value          (min_value)
	);

endmodule
